@@ src/cmas_pkg.sv @@
// Shared types, codes and helper functions for the CIGAR/MD alignment statistics block.
// No dependencies; imported by every module under src.
package cmas_pkg;

   localparam int LEN_W = 28;
   localparam int POS_W = 31;

   localparam logic [1:0] OP_CIGAR = 2'd0;
   localparam logic [1:0] OP_MD    = 2'd1;
   localparam logic [1:0] OP_EOR   = 2'd2;

   localparam logic [3:0] CIG_M   = 4'd0;
   localparam logic [3:0] CIG_I   = 4'd1;
   localparam logic [3:0] CIG_D   = 4'd2;
   localparam logic [3:0] CIG_S   = 4'd4;
   localparam logic [3:0] CIG_H   = 4'd5;
   localparam logic [3:0] CIG_EQ  = 4'd7;
   localparam logic [3:0] CIG_X   = 4'd8;

   localparam logic [1:0] MD_MATCH    = 2'd0;
   localparam logic [1:0] MD_MISMATCH = 2'd1;
   localparam logic [1:0] MD_DEL      = 2'd2;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_CARET = 8'h5E;

   localparam logic [LEN_W-1:0] THRESH_RESET = LEN_W'(10);

   typedef struct packed {
      logic [1:0]       operation;
      logic [3:0]       cigar_op;
      logic [LEN_W-1:0] cigar_len;
      logic [7:0]       md_char;
      logic             unmapped;
   } item_type;

   typedef struct packed {
      logic step;
      logic clear;
   } ctl_type;

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] max);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, max}) ? max : s[63:0];
   endfunction

   function automatic logic [31:0] out_count(logic [63:0] v);
      return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

@@ src/cmas_cigar.sv @@
// CIGAR side: read position, aligned span, insertion and deletion totals.
// Depends on cmas_pkg.
module cmas_cigar #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmas_pkg::ctl_type            ctl,
   input  cmas_pkg::item_type           item,
   input  logic [cmas_pkg::LEN_W-1:0]   threshold,
   output logic                         span_set,
   output logic [cmas_pkg::POS_W-1:0]   span_first,
   output logic [cmas_pkg::POS_W-1:0]   span_last,
   output logic [COUNT_WIDTH-1:0]       short_total,
   output logic [COUNT_WIDTH-1:0]       long_total,
   output logic [COUNT_WIDTH-1:0]       del_total
);
   import cmas_pkg::*;

   localparam logic [63:0] CNT_MAX = 64'({COUNT_WIDTH{1'b1}});

   logic [POS_W-1:0]       rpos_ff, rpos_in, rpos_adv;
   logic                   set_ff, set_in;
   logic [POS_W-1:0]       first_ff, first_in, last_ff, last_in;
   logic [COUNT_WIDTH-1:0] short_ff, short_in, long_ff, long_in, del_ff, del_in;
   logic [POS_W:0]         psum;
   logic [63:0]            len64;

   assign len64    = 64'(item.cigar_len);
   assign psum     = {1'b0, rpos_ff} + (POS_W + 1)'(item.cigar_len);
   assign rpos_adv = psum[POS_W] ? {POS_W{1'b1}} : psum[POS_W-1:0];

   always_comb begin
      rpos_in  = rpos_ff;
      set_in   = set_ff;
      first_in = first_ff;
      last_in  = last_ff;
      short_in = short_ff;
      long_in  = long_ff;
      del_in   = del_ff;
      if (ctl.clear) begin
         rpos_in  = '0;
         set_in   = 1'b0;
         short_in = '0;
         long_in  = '0;
         del_in   = '0;
      end else if (ctl.step && item.operation == OP_CIGAR) begin
         case (item.cigar_op)
            CIG_S, CIG_H: begin
               rpos_in = rpos_adv;
            end
            CIG_D: begin
               del_in = COUNT_WIDTH'(sat_add(64'(del_ff), len64, CNT_MAX));
            end
            CIG_I, CIG_M, CIG_EQ, CIG_X: begin
               if (item.cigar_op == CIG_I) begin
                  if (item.cigar_len >= threshold)
                     long_in = COUNT_WIDTH'(sat_add(64'(long_ff), len64, CNT_MAX));
                  else
                     short_in = COUNT_WIDTH'(sat_add(64'(short_ff), len64, CNT_MAX));
               end
               if (!set_ff) begin
                  set_in   = 1'b1;
                  first_in = rpos_ff;
               end
               rpos_in = rpos_adv;
               last_in = rpos_adv;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpos_ff  <= '0;
         set_ff   <= 1'b0;
         short_ff <= '0;
         long_ff  <= '0;
         del_ff   <= '0;
      end else begin
         rpos_ff  <= rpos_in;
         set_ff   <= set_in;
         short_ff <= short_in;
         long_ff  <= long_in;
         del_ff   <= del_in;
      end
      first_ff <= first_in;
      last_ff  <= last_in;
   end

   assign span_set    = set_ff;
   assign span_first  = first_ff;
   assign span_last   = last_ff;
   assign short_total = short_ff;
   assign long_total  = long_ff;
   assign del_total   = del_ff;

endmodule

@@ src/cmas_md.sv @@
// MD tag parser: match/mismatch/deletion state and the mismatch total.
// Depends on cmas_pkg.
module cmas_md #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmas_pkg::ctl_type      ctl,
   input  cmas_pkg::item_type     item,
   output logic [COUNT_WIDTH-1:0] mismatch_closed
);
   import cmas_pkg::*;

   localparam logic [63:0] CNT_MAX = 64'({COUNT_WIDTH{1'b1}});

   logic [1:0]             mode_ff, mode_in;
   logic [31:0]            run_ff, run_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in, closed;
   logic                   is_digit, is_caret;

   assign is_digit = (item.md_char >= CHAR_0) && (item.md_char <= CHAR_9);
   assign is_caret = (item.md_char == CHAR_CARET);
   assign closed   = (mode_ff == MD_MISMATCH)
                     ? COUNT_WIDTH'(sat_add(64'(total_ff), 64'(run_ff), CNT_MAX)) : total_ff;

   always_comb begin
      mode_in  = mode_ff;
      run_in   = run_ff + 32'd1;
      total_in = total_ff;
      if (ctl.clear) begin
         mode_in  = MD_MATCH;
         run_in   = '0;
         total_in = '0;
      end else if (ctl.step && item.operation == OP_MD) begin
         if (is_digit) begin
            if (mode_ff != MD_MATCH) begin
               total_in = closed;
               mode_in  = MD_MATCH;
               run_in   = 32'd1;
            end
         end else if (is_caret) begin
            total_in = closed;
            mode_in  = MD_DEL;
            run_in   = 32'd1;
         end else if (mode_ff == MD_MATCH) begin
            mode_in = MD_MISMATCH;
            run_in  = 32'd1;
         end
      end else begin
         run_in = run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MD_MATCH;
         run_ff   <= '0;
         total_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         run_ff   <= run_in;
         total_ff <= total_in;
      end
   end

   assign mismatch_closed = closed;

endmodule

@@ src/cigar_md_alignment_stats.sv @@
// Top level of the CIGAR/MD alignment statistics block: input register, threshold CSR,
// result register. Depends on cmas_pkg, cmas_cigar and cmas_md.
//
// Items are taken one per cycle at full rate while req_stall is low. Each accepted item
// is registered in the input register, then updates the per-record state. A result is
// captured into the result register when the end-of-record item in the input register
// advances. Stall on the result side holds the input only when an end-of-record item
// needs the occupied result register. Records marked unmapped produce no result.
module cigar_md_alignment_stats #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cmas_pkg::LEN_W-1:0]    csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [3:0]                    req_cigar_op,
   input  logic [cmas_pkg::LEN_W-1:0]    req_cigar_len,
   input  logic [7:0]                    req_md_char,
   input  logic                          req_unmapped,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_span_start,
   output logic signed [31:0]            rsp_span_end,
   output logic [30:0]                   rsp_span_length,
   output logic [31:0]                   rsp_mismatch_count,
   output logic [31:0]                   rsp_short_insertions,
   output logic [31:0]                   rsp_long_insertions,
   output logic [31:0]                   rsp_deleted_bases
);
   import cmas_pkg::*;

   logic [LEN_W-1:0]       thresh_ff;
   logic                   in_valid_ff, in_valid_in;
   item_type               item_ff;
   logic                   emit, adv, accept;
   ctl_type                ctl;
   logic                   span_set;
   logic [POS_W-1:0]       span_first, span_last;
   logic [COUNT_WIDTH-1:0] short_total, long_total, del_total, mis_total;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]     start_ff, end_ff;
   logic [30:0]            length_ff;
   logic [31:0]            mis_ff, short_ff, long_ff, del_ff;

   assign emit      = (item_ff.operation == OP_EOR) && !item_ff.unmapped;
   assign adv       = in_valid_ff && (!emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;
   assign ctl.step  = adv;
   assign ctl.clear = adv && (item_ff.operation == OP_EOR);

   assign in_valid_in  = accept ? 1'b1 : (adv ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (adv && emit) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en)
            thresh_ff <= csr_wr_data;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         item_ff.operation <= req_operation;
         item_ff.cigar_op  <= req_cigar_op;
         item_ff.cigar_len <= req_cigar_len;
         item_ff.md_char   <= req_md_char;
         item_ff.unmapped  <= req_unmapped;
      end
      if (adv && emit) begin
         start_ff  <= span_set ? $signed({1'b0, span_first}) : -32'sd1;
         end_ff    <= span_set ? $signed({1'b0, span_last}) : -32'sd1;
         length_ff <= span_set ? 31'(span_last - span_first) : 31'd0;
         mis_ff    <= out_count(64'(mis_total));
         short_ff  <= out_count(64'(short_total));
         long_ff   <= out_count(64'(long_total));
         del_ff    <= out_count(64'(del_total));
      end
   end

   cmas_cigar #(.COUNT_WIDTH(COUNT_WIDTH)) u_cigar (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .item        (item_ff),
      .threshold   (thresh_ff),
      .span_set    (span_set),
      .span_first  (span_first),
      .span_last   (span_last),
      .short_total (short_total),
      .long_total  (long_total),
      .del_total   (del_total)
   );

   cmas_md #(.COUNT_WIDTH(COUNT_WIDTH)) u_md (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .item            (item_ff),
      .mismatch_closed (mis_total)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_span_start       = start_ff;
   assign rsp_span_end         = end_ff;
   assign rsp_span_length      = length_ff;
   assign rsp_mismatch_count   = mis_ff;
   assign rsp_short_insertions = short_ff;
   assign rsp_long_insertions  = long_ff;
   assign rsp_deleted_bases    = del_ff;

   a_len_matches_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_span_length == 31'(rsp_span_end - rsp_span_start))
      else $error("span length disagrees with span bounds");

   a_span_both_unset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_span_start == -32'sd1 |-> rsp_span_end == -32'sd1)
      else $error("span end set without span start");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && emit && rsp_valid_ff)
      else $error("input stalled with no blocked result");

   a_no_emit_keeps_rsp: assert property (@(posedge clock) disable iff (reset)
      !(adv && emit) && rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(mis_ff))
      else $error("result register changed without a transfer");

endmodule
